FILE: design/skpq_pkg.sv
// ============================================================================
// skpq_pkg
// Shared types and constants for the sorted-key priority queue.
// ============================================================================
package skpq_pkg;

    // Table geometry and field widths
    localparam int MAX_ENTRIES = 16;
    localparam int ID_BITS     = 8;
    localparam int KEY_BITS    = 24;
    localparam int IDX_BITS    = $clog2(MAX_ENTRIES);
    localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);

    // Action codes
    localparam logic [2:0] ACT_ADD      = 3'd0;
    localparam logic [2:0] ACT_REMOVE   = 3'd1;
    localparam logic [2:0] ACT_SET_KEY  = 3'd2;
    localparam logic [2:0] ACT_SET_HEAD = 3'd3;
    localparam logic [2:0] ACT_END_TURN = 3'd4;
    localparam logic [2:0] ACT_CLEAR    = 3'd5;

    // Status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;
    localparam logic [1:0] STS_EMPTY     = 2'd3;

    // One table slot
    typedef struct packed {
        logic [ID_BITS-1:0]  id;
        logic [KEY_BITS-1:0] key;
    } t_entry;

endpackage

FILE: design/skpq_table.sv
// ============================================================================
// skpq_table
// Entry store: one write port, one read port with registered read data.
// ============================================================================
module skpq_table (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [skpq_pkg::IDX_BITS-1:0]   i_waddr,
    input  skpq_pkg::t_entry                i_wdata,
    input  logic [skpq_pkg::IDX_BITS-1:0]   i_raddr,
    output skpq_pkg::t_entry                o_rdata
);

    skpq_pkg::t_entry r_mem [skpq_pkg::MAX_ENTRIES];
    skpq_pkg::t_entry r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/sorted_key_priority_queue.sv
// ============================================================================
// sorted_key_priority_queue
// Table of (id, key) entries kept sorted by ascending key. A small sequencer
// walks the table one slot per cycle through shared key and id comparators,
// shifting entries by one slot while the moving entry waits in a register.
// ============================================================================
//
//  channel   handshake          payload
//  -------   ----------------   ------------------------------------------------
//  command   start / busy       i_action, i_entity_id, i_key
//  result    o_done (1 cycle)   o_status, o_head_valid, o_head_id, o_head_key,
//                               o_current_id, o_entry_count
//
//  A command is taken when start is high and busy is low; busy then stays high
//  until the result beat. Clear, end turn, full and empty-table cases go
//  straight to the head fetch; add moves the new entry up from the tail; remove
//  and rekey scan from the head for the id, then shift entries to close the gap
//  or to re-sort. The entry store reads one slot per cycle, which paces each walk.
//  Synchronous active-low reset empties the table and clears current id.
//  The result beat cannot be held off; busy is low during it.
//
module sorted_key_priority_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [2:0]                     i_action,
    input  logic [skpq_pkg::ID_BITS-1:0]   i_entity_id,
    input  logic [skpq_pkg::KEY_BITS-1:0]  i_key,
    output logic                           o_done,
    output logic [1:0]                     o_status,
    output logic                           o_head_valid,
    output logic [skpq_pkg::ID_BITS-1:0]   o_head_id,
    output logic [skpq_pkg::KEY_BITS-1:0]  o_head_key,
    output logic [skpq_pkg::ID_BITS-1:0]   o_current_id,
    output logic [skpq_pkg::CNT_BITS-1:0]  o_entry_count
);

    localparam int IW = skpq_pkg::IDX_BITS;
    localparam int CW = skpq_pkg::CNT_BITS;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FIND  = 8'b0000_0010,
        S_UP    = 8'b0000_0100,
        S_DOWN  = 8'b0000_1000,
        S_CLOSE = 8'b0001_0000,
        S_PLACE = 8'b0010_0000,
        S_HEAD  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state                         r_state, n_state;
    logic [2:0]                     r_action, n_action;
    logic [skpq_pkg::ID_BITS-1:0]   r_id, n_id;
    logic [skpq_pkg::KEY_BITS-1:0]  r_key, n_key;
    skpq_pkg::t_entry               r_mov, n_mov;
    logic [IW-1:0]                  r_pos, n_pos;
    logic                           r_moved, n_moved;
    logic [CW-1:0]                  r_count, n_count;
    logic [skpq_pkg::ID_BITS-1:0]   r_current, n_current;
    logic [1:0]                     r_status, n_status;
    logic                           r_done;
    logic [skpq_pkg::ID_BITS-1:0]   r_head_id;
    logic [skpq_pkg::KEY_BITS-1:0]  r_head_key;

    // Store port signals
    logic                           we;
    logic [IW-1:0]                  waddr;
    skpq_pkg::t_entry               wdata;
    logic [IW-1:0]                  raddr;
    skpq_pkg::t_entry               rdata;

    // Shared comparators and position arithmetic
    logic [IW-1:0]                  pos_inc, pos_dec;
    logic                           inc_in_table;   // r_pos+1 below count
    logic                           inc2_in_table;  // r_pos+2 below count
    logic                           id_hit;
    logic                           rd_key_gt;      // stored key > moving key
    logic                           mov_key_gt;     // moving key > stored key

    assign pos_inc       = r_pos + IW'(1);
    assign pos_dec       = r_pos - IW'(1);
    assign inc_in_table  = (CW'(r_pos) + CW'(1)) < r_count;
    assign inc2_in_table = (CW'(r_pos) + CW'(2)) < r_count;
    assign id_hit        = (r_action == skpq_pkg::ACT_SET_HEAD) || (rdata.id == r_id);
    assign rd_key_gt     = rdata.key > r_mov.key;
    assign mov_key_gt    = r_mov.key > rdata.key;

    skpq_table u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_action  = r_action;
        n_id      = r_id;
        n_key     = r_key;
        n_mov     = r_mov;
        n_pos     = r_pos;
        n_moved   = r_moved;
        n_count   = r_count;
        n_current = r_current;
        n_status  = r_status;
        we        = 1'b0;
        waddr     = r_pos;
        wdata     = r_mov;
        raddr     = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_action = i_action;
                    n_id     = i_entity_id;
                    n_key    = i_key;
                    n_status = skpq_pkg::STS_OK;
                    n_moved  = 1'b0;
                    n_pos    = '0;
                    n_state  = S_HEAD;
                    case (i_action)
                        skpq_pkg::ACT_ADD: begin
                            if (r_count == CW'(skpq_pkg::MAX_ENTRIES)) begin
                                n_status = skpq_pkg::STS_FULL;
                            end else begin
                                n_mov.id  = i_entity_id;
                                n_mov.key = i_key;
                                n_pos     = IW'(r_count);
                                n_count   = r_count + CW'(1);
                                if (r_count != '0) begin
                                    raddr   = IW'(r_count - CW'(1));
                                    n_state = S_UP;
                                end else begin
                                    n_state = S_PLACE;
                                end
                            end
                        end
                        skpq_pkg::ACT_REMOVE, skpq_pkg::ACT_SET_KEY: begin
                            if (r_count == '0) begin
                                n_status = skpq_pkg::STS_NOT_FOUND;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        skpq_pkg::ACT_SET_HEAD: begin
                            if (r_count == '0) begin
                                n_status = skpq_pkg::STS_EMPTY;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        skpq_pkg::ACT_END_TURN: begin
                            if (r_count == '0) begin
                                n_status = skpq_pkg::STS_EMPTY;
                            end
                        end
                        skpq_pkg::ACT_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Scan from the head for the first matching id
            S_FIND: begin
                if (id_hit) begin
                    n_mov.id  = rdata.id;
                    n_mov.key = r_key;
                    if (r_action == skpq_pkg::ACT_REMOVE) begin
                        if (inc_in_table) begin
                            raddr   = pos_inc;
                            n_state = S_CLOSE;
                        end else begin
                            n_count = r_count - CW'(1);
                            n_state = S_HEAD;
                        end
                    end else if (r_pos != '0) begin
                        raddr   = pos_dec;
                        n_state = S_UP;
                    end else if (inc_in_table) begin
                        raddr   = pos_inc;
                        n_state = S_DOWN;
                    end else begin
                        n_state = S_PLACE;
                    end
                end else if (inc_in_table) begin
                    n_pos = pos_inc;
                    raddr = pos_inc;
                end else begin
                    n_status = skpq_pkg::STS_NOT_FOUND;
                    n_state  = S_HEAD;
                end
            end

            // Move toward the head while the previous key is greater
            S_UP: begin
                if (rd_key_gt) begin
                    we      = 1'b1;
                    wdata   = rdata;
                    n_pos   = pos_dec;
                    n_moved = 1'b1;
                    if (pos_dec != '0) begin
                        raddr = pos_dec - IW'(1);
                    end else begin
                        n_state = S_PLACE;
                    end
                end else if (!r_moved && inc_in_table) begin
                    raddr   = pos_inc;
                    n_state = S_DOWN;
                end else begin
                    n_state = S_PLACE;
                end
            end

            // Move toward the tail while the next key is smaller
            S_DOWN: begin
                if (mov_key_gt) begin
                    we    = 1'b1;
                    wdata = rdata;
                    n_pos = pos_inc;
                    if (inc2_in_table) begin
                        raddr = pos_inc + IW'(1);
                    end else begin
                        n_state = S_PLACE;
                    end
                end else begin
                    n_state = S_PLACE;
                end
            end

            // Close the gap left by a removed entry
            S_CLOSE: begin
                we    = 1'b1;
                wdata = rdata;
                n_pos = pos_inc;
                if (inc2_in_table) begin
                    raddr = pos_inc + IW'(1);
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_HEAD;
                end
            end

            S_PLACE: begin
                we      = 1'b1;
                n_state = S_HEAD;
            end

            // Fetch the head slot for the result beat
            S_HEAD: begin
                raddr   = '0;
                n_state = S_OUT;
            end

            S_OUT: begin
                if ((r_action == skpq_pkg::ACT_END_TURN) &&
                    (r_status == skpq_pkg::STS_OK)) begin
                    n_current = rdata.id;
                end
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_current <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_current <= n_current;
            r_done    <= (r_state == S_OUT);
        end
    end

    // Working and result payload registers
    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_id     <= n_id;
        r_key    <= n_key;
        r_mov    <= n_mov;
        r_pos    <= n_pos;
        r_moved  <= n_moved;
        r_status <= n_status;
        if (r_state == S_OUT) begin
            r_head_id  <= (r_count != '0) ? rdata.id  : '0;
            r_head_key <= (r_count != '0) ? rdata.key : '0;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_head_valid  = (r_count != '0);
    assign o_head_id     = r_head_id;
    assign o_head_key    = r_head_key;
    assign o_current_id  = r_current;
    assign o_entry_count = r_count;

    // Checks
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy fell without a result beat");

    a_write_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (CW'(waddr) < r_count))
        else $error("store write beyond the entry count");

    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == skpq_pkg::STS_FULL)) |->
            (o_entry_count == CW'(skpq_pkg::MAX_ENTRIES)))
        else $error("full status with room in the table");

    a_empty_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_head_valid) |-> ((o_head_id == '0) && (o_head_key == '0)))
        else $error("head fields nonzero on an empty table");

endmodule
